[hdl/u8u16_pkg.sv]
// ----------------------------------------------------------------------------
// u8u16_pkg
// types and constants shared by the strict utf-8 to utf-16 transcoder
// ----------------------------------------------------------------------------
package u8u16_pkg;

	typedef struct packed {
		logic [7:0] byte_in;
		logic       end_of_string;
	} in_req_t;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        status;
		logic        run_last;
		logic        string_done;
	} out_req_t;

	localparam int unsigned FifoDepth = 4;

	localparam logic [7:0]  LEAD2_LO   = 8'hC2;
	localparam logic [7:0]  LEAD2_HI   = 8'hDF;
	localparam logic [7:0]  LEAD3_LO   = 8'hE0;
	localparam logic [7:0]  LEAD3_HI   = 8'hEF;
	localparam logic [7:0]  LEAD4_LO   = 8'hF0;
	localparam logic [7:0]  LEAD4_HI   = 8'hF4;
	localparam logic [7:0]  LEAD_E0    = 8'hE0;
	localparam logic [7:0]  LEAD_ED    = 8'hED;
	localparam logic [7:0]  LEAD_F0    = 8'hF0;
	localparam logic [7:0]  LEAD_F4    = 8'hF4;
	localparam logic [7:0]  CONT_LO    = 8'h80;
	localparam logic [7:0]  CONT_HI    = 8'hBF;
	localparam logic [7:0]  CONT_E0_LO = 8'hA0;
	localparam logic [7:0]  CONT_ED_HI = 8'h9F;
	localparam logic [7:0]  CONT_F0_LO = 8'h90;
	localparam logic [7:0]  CONT_F4_HI = 8'h8F;
	localparam logic [7:0]  PRINT_LO   = 8'h20;
	localparam logic [7:0]  PRINT_HI   = 8'h7E;
	localparam logic [7:0]  CH_TAB     = 8'h09;
	localparam logic [7:0]  CH_LF      = 8'h0A;
	localparam logic [7:0]  CH_CR      = 8'h0D;
	localparam logic [15:0] BOM_UNIT   = 16'hFEFF;
	localparam logic [15:0] HI_SURR    = 16'hD800;
	localparam logic [15:0] LO_SURR    = 16'hDC00;
	localparam logic [20:0] PLANE1     = 21'h010000;
	localparam logic        ST_DATA    = 1'b0;
	localparam logic        ST_ERROR   = 1'b1;

endpackage

[hdl/strict_utf8_to_utf16_transcoder.sv]
// ----------------------------------------------------------------------------
// strict_utf8_to_utf16_transcoder
// path: input register, then decode into the result queue that drives dst
// throughput: 1 byte per cycle while the queue holds at most 2 results;
// two results take 2 slots; the 4-entry queue sets the rate once dst stalls
// reset: asynchronous arst_n clears decode state, queue and emit_bom
// ----------------------------------------------------------------------------
// strict utf-8 decoder producing utf-16 code units, with optional bom
// ----------------------------------------------------------------------------
module strict_utf8_to_utf16_transcoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_data,
	input  logic                src_valid,
	output logic                src_stall,
	input  u8u16_pkg::in_req_t  src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output u8u16_pkg::out_req_t dst_data
);
	import u8u16_pkg::*;

	localparam int unsigned PtrW = $clog2(FifoDepth);
	localparam int unsigned CntW = $clog2(FifoDepth + 1);

	logic        emit_bom_q;
	logic        valid_s1;
	in_req_t     req_s1;
	logic [1:0]  pending_q;
	logic [20:0] partial_q;
	logic [7:0]  lead_q;
	logic [1:0]  seq_pos_q;
	logic        error_seen_q;
	logic        started_q;

	out_req_t      fifo_q [FifoDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	logic        advance;
	logic        pop;
	logic [1:0]  n_res;
	out_req_t    res0;
	out_req_t    res1;
	logic [1:0]  pending_d;
	logic [20:0] partial_d;
	logic [7:0]  lead_d;
	logic [1:0]  seq_pos_d;
	logic        error_seen_d;
	logic        started_d;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (cnt_q <= CntW'(FifoDepth - 2));
	assign src_stall = valid_s1 && !advance;
	assign dst_valid = (cnt_q != '0);
	assign pop       = dst_valid && !dst_stall;
	assign dst_data  = fifo_q[rd_ptr_q];

	always_comb begin
		logic [7:0]  b;
		logic        eos;
		logic        bad;
		logic        bom;
		logic [1:0]  nd;
		logic [15:0] ua;
		logic [15:0] ub;
		logic [7:0]  lo;
		logic [7:0]  hi;
		logic [20:0] np;
		logic [19:0] v;
		out_req_t    res [2];
		logic [1:0]  n;

		b            = req_s1.byte_in;
		eos          = req_s1.end_of_string;
		bad          = 1'b0;
		bom          = 1'b0;
		nd           = 2'd0;
		ua           = '0;
		ub           = '0;
		lo           = CONT_LO;
		hi           = CONT_HI;
		np           = {partial_q[14:0], b[5:0]};
		v            = 20'(np - PLANE1);
		pending_d    = pending_q;
		partial_d    = partial_q;
		lead_d       = lead_q;
		seq_pos_d    = seq_pos_q;
		error_seen_d = error_seen_q;
		started_d    = started_q;
		res[0]       = '0;
		res[1]       = '0;
		n            = 2'd0;

		if (!error_seen_q) begin
			started_d = 1'b1;
			bom       = !started_q && emit_bom_q;
			if (pending_q == 2'd0) begin
				if (b == CH_TAB || b == CH_LF || b == CH_CR || b inside {[PRINT_LO:PRINT_HI]}) begin
					nd = 2'd1;
					ua = {8'h00, b};
				end else if (b inside {[LEAD2_LO:LEAD2_HI]}) begin
					pending_d = 2'd1;
					partial_d = {16'h0, b[4:0]};
					lead_d    = b;
					seq_pos_d = 2'd0;
				end else if (b inside {[LEAD3_LO:LEAD3_HI]}) begin
					pending_d = 2'd2;
					partial_d = {17'h0, b[3:0]};
					lead_d    = b;
					seq_pos_d = 2'd0;
				end else if (b inside {[LEAD4_LO:LEAD4_HI]}) begin
					pending_d = 2'd3;
					partial_d = {18'h0, b[2:0]};
					lead_d    = b;
					seq_pos_d = 2'd0;
				end else begin
					bad = 1'b1;
				end
			end else begin
				if (seq_pos_q == 2'd0) begin
					if (lead_q == LEAD_E0) begin
						lo = CONT_E0_LO;
					end else if (lead_q == LEAD_ED) begin
						hi = CONT_ED_HI;
					end else if (lead_q == LEAD_F0) begin
						lo = CONT_F0_LO;
					end else if (lead_q == LEAD_F4) begin
						hi = CONT_F4_HI;
					end
				end
				if (b >= lo && b <= hi) begin
					partial_d = np;
					pending_d = pending_q - 2'd1;
					seq_pos_d = seq_pos_q + 2'd1;
					if (pending_q == 2'd1) begin
						if (np < PLANE1) begin
							nd = 2'd1;
							ua = np[15:0];
						end else begin
							nd = 2'd2;
							ua = HI_SURR + {6'h0, v[19:10]};
							ub = LO_SURR + {6'h0, v[9:0]};
						end
						partial_d = '0;
						lead_d    = '0;
						seq_pos_d = 2'd0;
					end
				end else begin
					bad = 1'b1;
				end
			end

			if (!bad && eos && pending_d != 2'd0) begin
				bad = 1'b1;
			end

			if (bom) begin
				res[0] = '{code_unit: BOM_UNIT, status: ST_DATA, run_last: 1'b0,
					string_done: 1'b0};
				n = n + 2'd1;
			end
			if (nd != 2'd0) begin
				res[n[0]] = '{code_unit: ua, status: ST_DATA, run_last: 1'b0,
					string_done: 1'b0};
				n = n + 2'd1;
			end
			if (nd == 2'd2) begin
				res[n[0]] = '{code_unit: ub, status: ST_DATA, run_last: 1'b0,
					string_done: 1'b0};
				n = n + 2'd1;
			end
			if (bad) begin
				res[n[0]] = '{code_unit: 16'h0, status: ST_ERROR, run_last: 1'b0,
					string_done: 1'b0};
				n = n + 2'd1;
				error_seen_d = 1'b1;
				pending_d    = 2'd0;
				partial_d    = '0;
				lead_d       = '0;
				seq_pos_d    = 2'd0;
			end
			if (n != 2'd0) begin
				res[n[0] ^ 1'b1].run_last    = 1'b1;
				res[n[0] ^ 1'b1].string_done = eos;
			end
		end

		if (eos) begin
			pending_d    = 2'd0;
			partial_d    = '0;
			lead_d       = '0;
			seq_pos_d    = 2'd0;
			error_seen_d = 1'b0;
			started_d    = 1'b0;
		end

		res0  = res[0];
		res1  = res[1];
		n_res = n;
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_bom_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			emit_bom_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!src_stall) begin
			valid_s1 <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			req_s1 <= src_data;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= 2'd0;
			partial_q    <= '0;
			lead_q       <= '0;
			seq_pos_q    <= 2'd0;
			error_seen_q <= 1'b0;
			started_q    <= 1'b0;
		end else if (advance) begin
			pending_q    <= pending_d;
			partial_q    <= partial_d;
			lead_q       <= lead_d;
			seq_pos_q    <= seq_pos_d;
			error_seen_q <= error_seen_d;
			started_q    <= started_d;
		end
	end

	// result queue
	always_ff @(posedge clk) begin
		if (advance && n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (advance && n_res == 2'd2) begin
			fifo_q[wr_ptr_q + PtrW'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(n_res);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			cnt_q <= cnt_q + (advance ? CntW'(n_res) : CntW'(0)) - (pop ? CntW'(1) : CntW'(0));
		end
	end

endmodule
